// ----- src/mcfsm_pkg.sv -----
// Shared types, phase codes, register indexes and control-word table for the control FSM.
package mcfsm_pkg;

	localparam int PHASE_W   = 4;
	localparam int OPCODE_W  = 6;
	localparam int FUNCT_W   = 6;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// Phase codes.
	localparam logic [PHASE_W-1:0] PH_FETCH      = 4'd0;
	localparam logic [PHASE_W-1:0] PH_DECODE     = 4'd1;
	localparam logic [PHASE_W-1:0] PH_EXEC       = 4'd2;
	localparam logic [PHASE_W-1:0] PH_LOAD_MEM   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_LOAD_WB    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_STORE_MEM  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_ADDI_WB    = 4'd6;
	localparam logic [PHASE_W-1:0] PH_RTYPE_EXEC = 4'd7;
	localparam logic [PHASE_W-1:0] PH_RTYPE_WB   = 4'd8;
	localparam logic [PHASE_W-1:0] PH_BRANCH     = 4'd9;
	localparam logic [PHASE_W-1:0] PH_JUMP       = 4'd10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ADDI   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STORE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RTYPE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRANCH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP   = 3'd5;

	// Reset opcode values.
	localparam logic [OPCODE_W-1:0] RST_ADDI   = 6'd8;
	localparam logic [OPCODE_W-1:0] RST_LOAD   = 6'd35;
	localparam logic [OPCODE_W-1:0] RST_STORE  = 6'd43;
	localparam logic [OPCODE_W-1:0] RST_RTYPE  = 6'd0;
	localparam logic [OPCODE_W-1:0] RST_BRANCH = 6'd4;
	localparam logic [OPCODE_W-1:0] RST_JUMP   = 6'd2;

	// Field encodings.
	localparam logic [1:0] SRC_B_REG = 2'd0;
	localparam logic [1:0] SRC_B_ONE = 2'd1;
	localparam logic [1:0] SRC_B_IMM = 2'd2;
	localparam logic [OPCODE_W-1:0] ALU_ADD = 6'd0;
	localparam logic [OPCODE_W-1:0] ALU_SUB = 6'd2;
	localparam logic [1:0] PC_ALU    = 2'd0;
	localparam logic [1:0] PC_BRANCH = 2'd1;
	localparam logic [1:0] PC_JUMP   = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0] addi_code;
		logic [OPCODE_W-1:0] load_code;
		logic [OPCODE_W-1:0] store_code;
		logic [OPCODE_W-1:0] rtype_code;
		logic [OPCODE_W-1:0] branch_eq_code;
		logic [OPCODE_W-1:0] jump_code;
	} opcode_regs_t;

	// Declared high field first so that write_memory lands in bit 0.
	typedef struct packed {
		logic                branch_enable;
		logic                memory_to_register;
		logic                write_register;
		logic                reg_dest;
		logic [1:0]          pc_select;
		logic                write_pc;
		logic [OPCODE_W-1:0] alu_op;
		logic [1:0]          alu_src_b;
		logic                write_ir;
		logic                imm_or_data;
		logic                alu_src_a;
		logic                write_memory;
	} ctrl_word_t;

	localparam int CTRL_W = $bits(ctrl_word_t);

	// Control word of a phase; unused phase codes give all zeros.
	function automatic ctrl_word_t ctrl_word(input logic [PHASE_W-1:0] ph,
	                                         input logic [FUNCT_W-1:0] fn);
		ctrl_word_t w;
		w = '0;
		case (ph)
			PH_FETCH: begin
				w.write_memory = 1'b1;
				w.write_ir     = 1'b1;
				w.alu_src_b    = SRC_B_ONE;
				w.write_pc     = 1'b1;
				w.reg_dest     = 1'b1;
			end
			PH_DECODE: begin
				w.alu_src_b = SRC_B_IMM;
				w.reg_dest  = 1'b1;
			end
			PH_EXEC: begin
				w.alu_src_a = 1'b1;
				w.alu_src_b = SRC_B_IMM;
			end
			PH_LOAD_MEM: begin
				w.alu_src_a   = 1'b1;
				w.imm_or_data = 1'b1;
				w.alu_src_b   = SRC_B_IMM;
			end
			PH_LOAD_WB: begin
				w.alu_src_a          = 1'b1;
				w.alu_src_b          = SRC_B_IMM;
				w.write_register     = 1'b1;
				w.memory_to_register = 1'b1;
			end
			PH_STORE_MEM: begin
				w.write_memory = 1'b1;
				w.alu_src_a    = 1'b1;
				w.imm_or_data  = 1'b1;
				w.alu_src_b    = SRC_B_IMM;
			end
			PH_ADDI_WB: begin
				w.alu_src_a      = 1'b1;
				w.alu_src_b      = SRC_B_IMM;
				w.write_register = 1'b1;
			end
			PH_RTYPE_EXEC: begin
				w.alu_src_a = 1'b1;
				w.alu_src_b = SRC_B_REG;
				w.alu_op    = fn;
				w.reg_dest  = 1'b1;
			end
			PH_RTYPE_WB: begin
				w.reg_dest       = 1'b1;
				w.write_register = 1'b1;
			end
			PH_BRANCH: begin
				w.alu_src_a     = 1'b1;
				w.alu_op        = ALU_SUB;
				w.pc_select     = PC_BRANCH;
				w.branch_enable = 1'b1;
			end
			PH_JUMP: begin
				w.write_pc  = 1'b1;
				w.pc_select = PC_JUMP;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- src/mcfsm_cfg.sv -----
// Opcode configuration registers with their write port.
module mcfsm_cfg
	import mcfsm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [OPCODE_W-1:0]  wr_data,
	output opcode_regs_t         codes
);

	opcode_regs_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.addi_code      <= RST_ADDI;
			codes_q.load_code      <= RST_LOAD;
			codes_q.store_code     <= RST_STORE;
			codes_q.rtype_code     <= RST_RTYPE;
			codes_q.branch_eq_code <= RST_BRANCH;
			codes_q.jump_code      <= RST_JUMP;
		end else if (wr_en) begin
			case (wr_index)
				REG_ADDI:   codes_q.addi_code      <= wr_data;
				REG_LOAD:   codes_q.load_code      <= wr_data;
				REG_STORE:  codes_q.store_code     <= wr_data;
				REG_RTYPE:  codes_q.rtype_code     <= wr_data;
				REG_BRANCH: codes_q.branch_eq_code <= wr_data;
				REG_JUMP:   codes_q.jump_code      <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign codes = codes_q;

endmodule

// ----- src/mcfsm_decode.sv -----
// Combinational control-word lookup and next-phase selection.
module mcfsm_decode
	import mcfsm_pkg::*;
(
	input  logic [PHASE_W-1:0]  phase,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [FUNCT_W-1:0]  function_code,
	input  opcode_regs_t        codes,
	output ctrl_word_t          word,
	output logic [PHASE_W-1:0]  next_phase
);

	assign word = ctrl_word(phase, function_code);

	// Priority of the opcode matches follows the order of the if chains.
	always_comb begin
		next_phase = PH_FETCH;
		case (phase)
			PH_FETCH: next_phase = PH_DECODE;
			PH_DECODE: begin
				if (opcode == codes.addi_code || opcode == codes.load_code ||
				    opcode == codes.store_code)
					next_phase = PH_EXEC;
				else if (opcode == codes.rtype_code)
					next_phase = PH_RTYPE_EXEC;
				else if (opcode == codes.branch_eq_code)
					next_phase = PH_BRANCH;
				else if (opcode == codes.jump_code)
					next_phase = PH_JUMP;
				else
					next_phase = PH_FETCH;
			end
			PH_EXEC: begin
				if (opcode == codes.load_code)
					next_phase = PH_LOAD_MEM;
				else if (opcode == codes.store_code)
					next_phase = PH_STORE_MEM;
				else if (opcode == codes.addi_code)
					next_phase = PH_ADDI_WB;
				else
					next_phase = PH_FETCH;
			end
			PH_LOAD_MEM:   next_phase = PH_LOAD_WB;
			PH_RTYPE_EXEC: next_phase = PH_RTYPE_WB;
			default:       next_phase = PH_FETCH;
		endcase
	end

endmodule

// ----- src/multicycle_cpu_control_fsm_core.sv -----
// Top level of the multicycle processor control FSM.
//
// Usage:
// Each input beat on the s_axis channel carries the current opcode, the funct
// field and an advance flag. For every input beat the block returns exactly one
// beat on the m_axis channel holding the control word of the current phase.
// When advance is set the phase then moves to its successor, otherwise it holds.
// In R-type execute the funct field is passed through as the ALU operation.
// An opcode that matches none of the opcode registers in decode or
// address/execute sends the machine back to fetch.
//
// The cfg channel writes the six opcode registers (index 0 addi, 1 load,
// 2 store, 3 R-type, 4 branch, 5 jump); other indexes are ignored. It is
// always ready and should be used only while no beat is in flight.
//
// The path from input beat to result beat is one input register, then the table
// lookup and next-phase logic into the result register. One beat is accepted
// per cycle for as long as the result side keeps taking them. When m_tready is
// low the result holds and the input register fills, after which s_tready
// drops. Reset puts the phase in fetch, empties both registers and loads the
// standard MIPS opcode values.
module multicycle_cpu_control_fsm_core
	import mcfsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// opcode [5:0], function_code [11:6], advance [12], zero fill above
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// write_memory [0], alu_src_a [1], imm_or_data [2], write_ir [3],
	// alu_src_b [5:4], alu_op [11:6], write_pc [12], pc_select [14:13],
	// reg_dest [15], write_register [16], memory_to_register [17],
	// branch_enable [18], zero fill above
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [OPCODE_W-1:0]   cfg_data
);

	opcode_regs_t codes;

	// Input register.
	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [FUNCT_W-1:0]  funct_s1;
	logic                adv_s1;

	// Result register.
	logic       valid_s2;
	ctrl_word_t word_s2;

	logic [PHASE_W-1:0] phase_q;
	ctrl_word_t         word;
	logic [PHASE_W-1:0] next_phase;
	logic               move_s1;
	logic               accept;

	assign cfg_ready = 1'b1;

	mcfsm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.codes    (codes)
	);

	mcfsm_decode u_decode (
		.phase         (phase_q),
		.opcode        (opcode_s1),
		.function_code (funct_s1),
		.codes         (codes),
		.word          (word),
		.next_phase    (next_phase)
	);

	// The input register drains into the result register whenever that one is
	// empty or being taken, and it refills in the same cycle.
	assign move_s1  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || move_s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= s_tdata[OPCODE_W-1:0];
			funct_s1  <= s_tdata[OPCODE_W+FUNCT_W-1:OPCODE_W];
			adv_s1    <= s_tdata[OPCODE_W+FUNCT_W];
		end
	end

	// The phase steps exactly when its beat's control word is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FETCH;
			valid_s2 <= 1'b0;
		end else begin
			if (move_s1 && adv_s1)
				phase_q <= next_phase;
			if (move_s1)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1)
			word_s2 <= word;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DATA_W-CTRL_W){1'b0}}, word_s2};

`ifndef SYNTHESIS
	// Only the eleven defined phases are ever reached.
	assert property (@(posedge clk) disable iff (!arst_n) phase_q <= PH_JUMP)
		else $error("phase left the defined range");

	// A beat without advance leaves the phase where it was.
	assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 && !adv_s1 |=> $stable(phase_q))
		else $error("phase moved without advance");

	// Fetch always steps to decode.
	assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 && adv_s1 && phase_q == PH_FETCH |=> phase_q == PH_DECODE)
		else $error("fetch did not step to decode");

	// A result that is not taken is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |-> !move_s1)
		else $error("pending result overwritten");
`endif

endmodule

// ----- tb/multicycle_cpu_control_fsm_core_tb.sv -----
// Self-checking testbench for the multicycle processor control FSM: directed, remap and random runs.
`timescale 1ns / 1ps

module multicycle_cpu_control_fsm_core_tb;
	import mcfsm_pkg::*;

	localparam int MAX_IDLE        = 14;
	localparam int STALL_LIMIT     = 1000;
	localparam int REPORT_MAX      = 10;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int RESET_CYCLES    = 10;
	localparam int DRAIN_CYCLES    = 4;
	localparam int NUM_CFG_INDEXES = 8;

	// Indexes past the last opcode register; the block must ignore writes to them.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// An opcode that none of the reset opcode values matches.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 6'd63;

	// Sets of phases in which a one-bit control signal is high. A phase code
	// outside every set (including the unused codes) gives zero.
	localparam logic [15:0] SET_WRITE_MEM = (16'd1 << PH_FETCH) | (16'd1 << PH_STORE_MEM);
	localparam logic [15:0] SET_SRC_A     = (16'd1 << PH_EXEC) | (16'd1 << PH_LOAD_MEM) |
	                                        (16'd1 << PH_LOAD_WB) | (16'd1 << PH_STORE_MEM) |
	                                        (16'd1 << PH_ADDI_WB) | (16'd1 << PH_RTYPE_EXEC) |
	                                        (16'd1 << PH_BRANCH);
	localparam logic [15:0] SET_ADDR_ALU  = (16'd1 << PH_LOAD_MEM) | (16'd1 << PH_STORE_MEM);
	localparam logic [15:0] SET_SRC_B_IMM = (16'd1 << PH_DECODE) | (16'd1 << PH_EXEC) |
	                                        (16'd1 << PH_LOAD_MEM) | (16'd1 << PH_LOAD_WB) |
	                                        (16'd1 << PH_STORE_MEM) | (16'd1 << PH_ADDI_WB);
	localparam logic [15:0] SET_WRITE_PC  = (16'd1 << PH_FETCH) | (16'd1 << PH_JUMP);
	localparam logic [15:0] SET_REG_RD    = (16'd1 << PH_FETCH) | (16'd1 << PH_DECODE) |
	                                        (16'd1 << PH_RTYPE_EXEC) | (16'd1 << PH_RTYPE_WB);
	localparam logic [15:0] SET_WRITE_REG = (16'd1 << PH_LOAD_WB) | (16'd1 << PH_ADDI_WB) |
	                                        (16'd1 << PH_RTYPE_WB);

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// opcode [5:0], function_code [11:6], advance [12], zero fill above
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// write_memory [0], alu_src_a [1], imm_or_data [2], write_ir [3],
	// alu_src_b [5:4], alu_op [11:6], write_pc [12], pc_select [14:13],
	// reg_dest [15], write_register [16], memory_to_register [17],
	// branch_enable [18], zero fill above
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [OPCODE_W-1:0]   cfg_data;

	// Shadow of the block: its phase and its opcode registers.
	logic [PHASE_W-1:0] model_phase;
	opcode_regs_t       model_opcodes;

	// Control words still owed by the block, oldest first.
	ctrl_word_t pending_ctrl_words[$];

	int unsigned mismatch_count = 0;
	int unsigned items_sent = 0;
	int          quiet_cycles = 0;
	int          hold_off_len = 0;
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;

	multicycle_cpu_control_fsm_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Control word the block shows while sitting in a phase.
	function automatic ctrl_word_t phase_controls(input logic [PHASE_W-1:0] ph,
	                                              input logic [FUNCT_W-1:0] fn);
		ctrl_word_t w;
		w = '0;
		w.write_memory       = SET_WRITE_MEM[ph];
		w.alu_src_a          = SET_SRC_A[ph];
		w.imm_or_data        = SET_ADDR_ALU[ph];
		w.write_ir           = (ph == PH_FETCH);
		w.alu_src_b          = (ph == PH_FETCH) ? SRC_B_ONE :
		                       SET_SRC_B_IMM[ph] ? SRC_B_IMM : SRC_B_REG;
		w.alu_op             = (ph == PH_RTYPE_EXEC) ? fn :
		                       (ph == PH_BRANCH) ? ALU_SUB : ALU_ADD;
		w.write_pc           = SET_WRITE_PC[ph];
		w.pc_select          = (ph == PH_BRANCH) ? PC_BRANCH :
		                       (ph == PH_JUMP) ? PC_JUMP : PC_ALU;
		w.reg_dest           = SET_REG_RD[ph];
		w.write_register     = SET_WRITE_REG[ph];
		w.memory_to_register = (ph == PH_LOAD_WB);
		w.branch_enable      = (ph == PH_BRANCH);
		return w;
	endfunction

	// Where the machine goes when advance is set. Decode and address/execute
	// compare the opcode in a fixed order, so the first matching register wins.
	function automatic logic [PHASE_W-1:0] successor_phase(input logic [PHASE_W-1:0] ph,
	                                                       input logic [OPCODE_W-1:0] op);
		case (ph)
			PH_FETCH: return PH_DECODE;
			PH_DECODE: begin
				if (op == model_opcodes.addi_code || op == model_opcodes.load_code ||
				    op == model_opcodes.store_code)
					return PH_EXEC;
				if (op == model_opcodes.rtype_code)
					return PH_RTYPE_EXEC;
				if (op == model_opcodes.branch_eq_code)
					return PH_BRANCH;
				if (op == model_opcodes.jump_code)
					return PH_JUMP;
				return PH_FETCH;
			end
			PH_EXEC: begin
				if (op == model_opcodes.load_code)
					return PH_LOAD_MEM;
				if (op == model_opcodes.store_code)
					return PH_STORE_MEM;
				if (op == model_opcodes.addi_code)
					return PH_ADDI_WB;
				return PH_FETCH;
			end
			PH_LOAD_MEM:   return PH_LOAD_WB;
			PH_RTYPE_EXEC: return PH_RTYPE_WB;
			default:       return PH_FETCH;
		endcase
	endfunction

	// Any six-bit value.
	function automatic logic [OPCODE_W-1:0] random_code();
		return OPCODE_W'($urandom_range(0, 63));
	endfunction

	// Mostly one of the programmed opcodes, sometimes anything at all.
	function automatic logic [OPCODE_W-1:0] pick_opcode();
		case ($urandom_range(0, 7))
			0:       return model_opcodes.addi_code;
			1:       return model_opcodes.load_code;
			2:       return model_opcodes.store_code;
			3:       return model_opcodes.rtype_code;
			4:       return model_opcodes.branch_eq_code;
			5:       return model_opcodes.jump_code;
			default: return random_code();
		endcase
	endfunction

	// A random setting of all six opcode registers.
	function automatic opcode_regs_t random_opcodes();
		opcode_regs_t r;
		r.addi_code      = random_code();
		r.load_code      = random_code();
		r.store_code     = random_code();
		r.rtype_code     = random_code();
		r.branch_eq_code = random_code();
		r.jump_code      = random_code();
		return r;
	endfunction

	task automatic compare_field(input string name, input int unsigned want,
	                             input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
		end
	endtask

	task automatic check_control_beat(input logic [OUT_DATA_W-1:0] data);
		ctrl_word_t got;
		ctrl_word_t want;
		got = data[CTRL_W-1:0];
		if (pending_ctrl_words.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("%0t: result beat 0x%0h with nothing expected", $realtime, data);
		end else begin
			want = pending_ctrl_words.pop_front();
			compare_field("write_memory", 32'(want.write_memory), 32'(got.write_memory));
			compare_field("alu_src_a", 32'(want.alu_src_a), 32'(got.alu_src_a));
			compare_field("imm_or_data", 32'(want.imm_or_data), 32'(got.imm_or_data));
			compare_field("write_ir", 32'(want.write_ir), 32'(got.write_ir));
			compare_field("alu_src_b", 32'(want.alu_src_b), 32'(got.alu_src_b));
			compare_field("alu_op", 32'(want.alu_op), 32'(got.alu_op));
			compare_field("write_pc", 32'(want.write_pc), 32'(got.write_pc));
			compare_field("pc_select", 32'(want.pc_select), 32'(got.pc_select));
			compare_field("reg_dest", 32'(want.reg_dest), 32'(got.reg_dest));
			compare_field("write_register", 32'(want.write_register),
			              32'(got.write_register));
			compare_field("memory_to_register", 32'(want.memory_to_register),
			              32'(got.memory_to_register));
			compare_field("branch_enable", 32'(want.branch_enable), 32'(got.branch_enable));
			compare_field("zero fill", 0, 32'(data >> CTRL_W));
		end
	endtask

	// Offers one input beat, after a random gap while tx_idle is set. The expected
	// control word is recorded, and the shadow phase stepped, at the edge that takes the beat.
	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [FUNCT_W-1:0] fn,
	                         input logic adv);
		int                   gap;
		logic [IN_DATA_W-1:0] beat;
		gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
		beat = '0;
		beat[5:0] = op;
		beat[11:6] = fn;
		beat[12] = adv;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= beat;
		do @(posedge clk); while (!s_tready);
		pending_ctrl_words.push_back(phase_controls(model_phase, fn));
		if (adv)
			model_phase = successor_phase(model_phase, op);
		items_sent++;
	endtask

	// Steps one instruction from fetch back to fetch without holding.
	task automatic run_instruction(input logic [OPCODE_W-1:0] op, input logic [FUNCT_W-1:0] fn);
		do send_item(op, fn, 1'b1); while (model_phase != PH_FETCH);
	endtask

	// Stops offering beats, waits until every owed result has come back and then
	// lets the block drain, so that it is idle.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pending_ctrl_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all six opcode registers and both spare indexes in one burst.
	task automatic configure(input opcode_regs_t regs);
		logic [CFG_IDX_W-1:0] idx;
		logic [OPCODE_W-1:0]  value;
		idx = '0;
		repeat (NUM_CFG_INDEXES) begin
			case (idx)
				REG_ADDI:     value = regs.addi_code;
				REG_LOAD:     value = regs.load_code;
				REG_STORE:    value = regs.store_code;
				REG_RTYPE:    value = regs.rtype_code;
				REG_BRANCH:   value = regs.branch_eq_code;
				REG_JUMP:     value = regs.jump_code;
				REG_SPARE_LO,
				REG_SPARE_HI: value = random_code();
				default:      value = '0;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= value;
			do @(posedge clk); while (!cfg_ready);
			idx++;
		end
		cfg_valid <= 1'b0;
		// Spare indexes leave the registers alone.
		model_opcodes = regs;
	endtask

	// Reset opcode values: addi and jump instructions, unknown opcodes in decode
	// and in address/execute, and holding with advance low.
	task automatic test_directed_defaults();
		send_item(OP_UNUSED, 6'h3F, 1'b0);
		run_instruction(RST_ADDI, 6'h2A);
		run_instruction(RST_JUMP, 6'h3F);
		run_instruction(OP_UNUSED, 6'h00);
		send_item(RST_ADDI, 6'h15, 1'b1);
		send_item(RST_ADDI, 6'h00, 1'b1);
		send_item(RST_LOAD, 6'h3F, 1'b0);
		send_item(OP_UNUSED, 6'h00, 1'b1);
	endtask

	// Equal opcode registers: the first match in each compare order wins.
	task automatic test_opcode_priority();
		quiesce();
		// Store beats addi in address/execute; R-type beats branch and jump in decode.
		configure({6'd10, 6'd63, 6'd10, 6'd5, 6'd5, 6'd5});
		run_instruction(6'd10, 6'h00);
		run_instruction(6'd5, 6'h3F);
		quiesce();
		// Everything at zero: decode goes to address/execute and load wins there.
		configure('0);
		run_instruction(6'd0, 6'h15);
		quiesce();
		// Branch beats jump.
		configure({6'd1, 6'd2, 6'd3, 6'd4, 6'd9, 6'd9});
		run_instruction(6'd9, 6'h2A);
	endtask

	// The result side holds off for a long stretch while beats keep coming,
	// so both pipeline registers fill and the block drops s_tready.
	task automatic test_backpressure_fill();
		quiesce();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_off_len = HOLD_OFF_CYCLES;
		repeat (6) run_instruction(pick_opcode(), random_code());
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Random instruction streams under one register setting. Most beats keep
	// the instruction's opcode; a few carry noise, and advance is sometimes low.
	task automatic test_random_programs(input opcode_regs_t regs, input int unsigned count);
		int unsigned         stop_at;
		logic [OPCODE_W-1:0] op;
		logic [OPCODE_W-1:0] noise;
		quiesce();
		configure(regs);
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 15) == 0)
				tx_idle = !tx_idle;
			if ($urandom_range(0, 15) == 0)
				rx_idle = !rx_idle;
			op = pick_opcode();
			do begin
				noise = random_code();
				send_item(($urandom_range(0, 19) == 0) ? noise : op, random_code(),
				          $urandom_range(0, 7) != 0);
			end while (model_phase != PH_FETCH);
		end
	endtask

	// Result side: stalls at random before each beat while rx_idle is set, or for
	// the long hold-off when one is requested, and checks every beat it takes.
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_len > 0) begin
				stall = hold_off_len;
				hold_off_len = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_control_beat(m_tdata);
		end
	end

	// Ends the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		model_phase = PH_FETCH;
		model_opcodes = {RST_ADDI, RST_LOAD, RST_STORE, RST_RTYPE, RST_BRANCH, RST_JUMP};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_opcode_priority();
		test_backpressure_fill();
		test_random_programs({RST_ADDI, RST_LOAD, RST_STORE, RST_RTYPE, RST_BRANCH, RST_JUMP}, 300);
		test_random_programs(random_opcodes(), 300);
		test_random_programs(random_opcodes(), 300);
		test_random_programs('0, 250);
		test_random_programs('1, 250);
		test_random_programs(random_opcodes(), 200);
		quiesce();

		if (mismatch_count == 0 && pending_ctrl_words.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
